// File: hw/rtl/tcpc_pkg.sv
// Shared types, constants and the CRC byte update for the telecommand packet checker.
package tcpc_pkg;

	// Byte counter width and its saturation point
	localparam int IDX_W = 17;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	// Packet layout
	localparam logic [IDX_W-1:0] HDR_BYTES   = 17'd16;
	localparam logic [IDX_W-1:0] MIN_PKT     = 17'd18;
	localparam logic [IDX_W-1:0] IDX_LEN_LO  = 17'd5;
	localparam logic [IDX_W-1:0] IDX_SEC_LO  = 17'd6;
	localparam logic [15:0]      LEN_BIAS    = 16'd11;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE    = 8'd1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_LEN_OVF     = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_TYPE    = 3'd4,
		ST_BAD_CRC     = 3'd5
	} status_t;

	// One input beat
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_last;
	} beat_t;

	// Checker settings
	typedef struct packed {
		logic [2:0] version;
		logic       ptype;
	} cfg_t;

	// One result beat
	typedef struct packed {
		logic        done_res;
		status_t     status;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [10:0] apid;
		logic [13:0] sequence_count;
		logic [7:0]  svc_class;
		logic [7:0]  svc_subclass;
		logic [7:0]  origin_id;
		logic [31:0] exec_stamp;
		logic [15:0] ack_mask;
		logic [8:0]  payload_len;
	} res_t;

	// Advance the CRC by one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/tcpc_if.sv
// Channel interfaces of the telecommand packet checker: byte input, result output, config write.
interface tcpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       is_last;

	modport source (output valid, output rx_byte, output is_last, input ready);
	modport sink   (input valid, input rx_byte, input is_last, output ready);
endinterface

interface tcpc_out_if;
	logic        valid;
	logic        ready;
	logic        done_res;
	logic [2:0]  status;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [10:0] apid;
	logic [13:0] sequence_count;
	logic [7:0]  svc_class;
	logic [7:0]  svc_subclass;
	logic [7:0]  origin_id;
	logic [31:0] exec_stamp;
	logic [15:0] ack_mask;
	logic [8:0]  payload_len;

	modport source (
		output valid, output done_res, output status, output data_valid, output data_byte,
		output apid, output sequence_count, output svc_class, output svc_subclass,
		output origin_id, output exec_stamp, output ack_mask, output payload_len,
		input ready
	);
	modport sink (
		input valid, input done_res, input status, input data_valid, input data_byte,
		input apid, input sequence_count, input svc_class, input svc_subclass,
		input origin_id, input exec_stamp, input ack_mask, input payload_len,
		output ready
	);
endinterface

interface tcpc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tc_space_packet_checker.sv
// Top level of the telecommand space packet checker.
//
//  channel  dir  handshake     payload
//  in       in   valid/ready   rx_byte[7:0], is_last
//  out      out  valid/ready   done_res, status[2:0], data fields, header fields
//  cfg      in   valid/ready   index[7:0], data[7:0]  (0 version, 1 type)
//
// One byte per cycle sustained while the result is drained; an input beat passes through the
// input register and then the result register, with the CRC byte update between them.
// Reset clears packet state, loads version 0 and type 1; no clearing pass.
// A stalled result holds the input register; a new byte is still taken while
// the result is being drained. cfg is always ready.
module tc_space_packet_checker #(
	parameter int unsigned MAX_DATA_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tcpc_in_if.sink    in,
	tcpc_out_if.source out,
	tcpc_cfg_if.sink   cfg
);
	import tcpc_pkg::*;

	logic  valid_s1;
	logic  take;
	beat_t beat_s1;
	cfg_t  cfg_q;

	tcpc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	tcpc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	tcpc_parser #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.cfg_q    (cfg_q),
		.take     (take),
		.out      (out)
	);

	// A held beat moves into an empty result register
	a_fill_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out.valid |=> out.valid)
		else $error("held beat did not reach the result register");

	// Both stages full and output stalled: no new beat
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out.valid && !out.ready |-> !in.ready)
		else $error("input accepted while both stages are stalled");

	// Error status only on the last byte of a packet
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.done_res |-> out.status == ST_OK)
		else $error("status set before the last byte");

	// Length overflow never passes data or a length
	a_ovf_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.status == ST_LEN_OVF |-> out.payload_len == 9'd0 && !out.data_valid)
		else $error("data passed on a length overflow");

endmodule

// File: hw/rtl/tcpc_in_reg.sv
// Input register stage: captures one byte beat and hands it to the parser.
module tcpc_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	tcpc_in_if.sink       in,
	input  logic          take,
	output logic          valid_s1,
	output tcpc_pkg::beat_t beat_s1
);
	import tcpc_pkg::*;

	// Accept while empty or while the held beat moves on
	assign in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	// Hold the payload until a new beat is accepted
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			beat_s1.rx_byte <= in.rx_byte;
			beat_s1.is_last <= in.is_last;
		end
	end

endmodule

// File: hw/rtl/tcpc_cfg_regs.sv
// Configuration registers: expected version and expected packet type.
module tcpc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	tcpc_cfg_if.sink      cfg,
	output tcpc_pkg::cfg_t cfg_q
);
	import tcpc_pkg::*;

	assign cfg.ready = 1'b1;

	// Write the addressed register; drop writes to other indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version <= 3'd0;
			cfg_q.ptype   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VERSION: cfg_q.version <= cfg.data[2:0];
				CFG_TYPE:    cfg_q.ptype   <= cfg.data[0];
				default:     ;
			endcase
		end
	end

endmodule

// File: hw/rtl/tcpc_parser.sv
// Packet parser: header capture, CRC update, status and the result register.
module tcpc_parser #(
	parameter int unsigned MAX_DATA_BYTES = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  tcpc_pkg::beat_t beat_s1,
	input  tcpc_pkg::cfg_t  cfg_q,
	output logic            take,
	tcpc_out_if.source      out
);
	import tcpc_pkg::*;

	localparam int UL_W = $clog2(MAX_DATA_BYTES + 1);
	localparam logic [IDX_W-1:0] MAX_DL = IDX_W'(MAX_DATA_BYTES);

	// Packet state
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [15:0]      crc_q, crc_n;
	logic [15:0]      pid_q, pid_n;
	logic [15:0]      seq_q, seq_n;
	logic [15:0]      len_q, len_n;
	logic [63:0]      sec_q, sec_n;
	logic [15:0]      ack_q, ack_n;
	logic [UL_W-1:0]  ul_q, ul_n;
	logic [15:0]      rcrc_q, rcrc_n;
	logic             ovf_q, ovf_n;

	logic             res_valid_q;
	res_t             res_q, res_n;

	logic [7:0]       b;
	logic [IDX_W-1:0] data_end;
	logic             dv;
	logic [15:0]      dl;
	logic [IDX_W-1:0] ul_ext;
	status_t          st;

	// Move the held beat when the result register is free or being drained
	assign take = valid_s1 && (!res_valid_q || out.ready);

	assign b        = beat_s1.rx_byte;
	assign data_end = HDR_BYTES + IDX_W'(ul_q);
	assign dv       = (idx_q >= HDR_BYTES) && !ovf_q && (idx_q < data_end);
	assign dl       = {len_q[15:8], b} - LEN_BIAS;

	// Next packet state for this byte
	always_comb begin
		pid_n  = pid_q;
		seq_n  = seq_q;
		len_n  = len_q;
		sec_n  = sec_q;
		ack_n  = ack_q;
		ul_n   = ul_q;
		rcrc_n = rcrc_q;
		ovf_n  = ovf_q;
		crc_n  = (idx_q < HDR_BYTES || dv) ? crc16_byte(crc_q, b) : crc_q;
		idx_n  = (idx_q != IDX_MAX) ? idx_q + 1'b1 : idx_q;

		priority if (idx_q == 17'd0) begin
			pid_n[15:8] = b;
		end else if (idx_q == 17'd1) begin
			pid_n[7:0] = b;
		end else if (idx_q == 17'd2) begin
			seq_n[15:8] = b;
		end else if (idx_q == 17'd3) begin
			seq_n[7:0] = b;
		end else if (idx_q == 17'd4) begin
			len_n[15:8] = b;
		end else if (idx_q == IDX_LEN_LO) begin
			len_n[7:0] = b;
			// Derive the data length once the length word is complete
			if ({1'b0, dl} > MAX_DL) begin
				ovf_n = 1'b1;
				ul_n  = '0;
			end else begin
				ul_n = UL_W'(dl);
			end
		end else if (idx_q < HDR_BYTES - 17'd2) begin
			for (int k = 0; k < 8; k++) begin
				if (idx_q == IDX_SEC_LO + IDX_W'(k)) begin
					sec_n[63 - 8*k -: 8] = b;
				end
			end
		end else if (idx_q == HDR_BYTES - 17'd2) begin
			ack_n[15:8] = b;
		end else if (idx_q == HDR_BYTES - 17'd1) begin
			ack_n[7:0] = b;
		end else if (!ovf_q) begin
			// Capture the trailing CRC; ignore anything after it
			if (idx_q == data_end) begin
				rcrc_n[15:8] = b;
			end else if (idx_q == data_end + 1'b1) begin
				rcrc_n[7:0] = b;
			end
		end else begin
		end
	end

	assign ul_ext = IDX_W'(ul_n);

	// Final status on the last byte, in priority order
	always_comb begin
		st = ST_OK;
		if (beat_s1.is_last) begin
			priority if (idx_n < MIN_PKT) begin
				st = ST_TOO_SHORT;
			end else if (ovf_n) begin
				st = ST_LEN_OVF;
			end else if (idx_n < MIN_PKT + ul_ext) begin
				st = ST_TOO_SHORT;
			end else if (pid_n[15:13] != cfg_q.version) begin
				st = ST_BAD_VERSION;
			end else if (pid_n[12] != cfg_q.ptype) begin
				st = ST_BAD_TYPE;
			end else if (crc_n != rcrc_n) begin
				st = ST_BAD_CRC;
			end else begin
				st = ST_OK;
			end
		end
	end

	// Assemble the result beat from the updated state
	always_comb begin
		res_n.done_res       = beat_s1.is_last;
		res_n.status         = st;
		res_n.data_valid     = dv;
		res_n.data_byte      = dv ? b : 8'd0;
		res_n.apid           = pid_n[10:0];
		res_n.sequence_count = seq_n[13:0];
		res_n.svc_class      = sec_n[63:56];
		res_n.svc_subclass   = sec_n[55:48];
		res_n.origin_id      = sec_n[47:40];
		res_n.exec_stamp     = sec_n[31:0];
		res_n.ack_mask       = ack_n;
		res_n.payload_len    = (idx_n > IDX_LEN_LO && !ovf_n) ? ul_ext[8:0] : 9'd0;
	end

	// Advance packet state; rearm after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			crc_q  <= CRC_INIT;
			pid_q  <= '0;
			seq_q  <= '0;
			len_q  <= '0;
			sec_q  <= '0;
			ack_q  <= '0;
			ul_q   <= '0;
			rcrc_q <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			if (beat_s1.is_last) begin
				idx_q  <= '0;
				crc_q  <= CRC_INIT;
				pid_q  <= '0;
				seq_q  <= '0;
				len_q  <= '0;
				sec_q  <= '0;
				ack_q  <= '0;
				ul_q   <= '0;
				rcrc_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				idx_q  <= idx_n;
				crc_q  <= crc_n;
				pid_q  <= pid_n;
				seq_q  <= seq_n;
				len_q  <= len_n;
				sec_q  <= sec_n;
				ack_q  <= ack_n;
				ul_q   <= ul_n;
				rcrc_q <= rcrc_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_n;
		end
	end

	assign out.valid          = res_valid_q;
	assign out.done_res       = res_q.done_res;
	assign out.status         = res_q.status;
	assign out.data_valid     = res_q.data_valid;
	assign out.data_byte      = res_q.data_byte;
	assign out.apid           = res_q.apid;
	assign out.sequence_count = res_q.sequence_count;
	assign out.svc_class      = res_q.svc_class;
	assign out.svc_subclass   = res_q.svc_subclass;
	assign out.origin_id      = res_q.origin_id;
	assign out.exec_stamp     = res_q.exec_stamp;
	assign out.ack_mask       = res_q.ack_mask;
	assign out.payload_len    = res_q.payload_len;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the telecommand space packet checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpc_pkg::*;

	localparam int unsigned MAX_DATA = 256;
	localparam int CYCLE_LIMIT  = 100_000;
	localparam int RANDOM_BEATS = 900;
	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_CYCLES = 400;
	localparam int LONG_TAIL    = 40;

	logic clk = 1'b0;
	logic arst_n;

	tcpc_in_if  byte_ch ();
	tcpc_out_if res_ch ();
	tcpc_cfg_if cfg_ch ();

	tc_space_packet_checker #(
		.MAX_DATA_BYTES(MAX_DATA)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (byte_ch),
		.out   (res_ch),
		.cfg   (cfg_ch)
	);

	// Parser shadow state and register copies
	logic [16:0] pkt_idx;
	logic [15:0] crc_run;
	logic [15:0] pid_w;
	logic [15:0] seq_w;
	logic [15:0] len_w;
	logic [63:0] sec_w;
	logic [15:0] ack_w;
	int          user_len;
	logic [15:0] rcv_crc;
	bit          len_ovf;
	logic [2:0]  cfg_ver;
	logic        cfg_typ;

	res_t       pending_results[$];
	logic [7:0] tx_pkt[$];

	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int stall_left    = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int packets_sent  = 0;
	int beats_sent    = 0;
	int settings_used = 0;
	int status_tally[6];

	// Clock: 1 ns high, 1 ns low
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// CRC-16/CCITT-FALSE, one bit at a time from the MSB of the byte
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r  = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ 16'h1021;
			end
		end
		return r;
	endfunction

	function automatic void clear_packet_state();
		pkt_idx  = '0;
		crc_run  = 16'hFFFF;
		pid_w    = '0;
		seq_w    = '0;
		len_w    = '0;
		sec_w    = '0;
		ack_w    = '0;
		user_len = 0;
		rcv_crc  = '0;
		len_ovf  = 1'b0;
	endfunction

	// Advance the shadow parser by one byte and return the result beat it produces
	function automatic res_t parse_byte(input logic [7:0] b, input logic last);
		int          idx;
		int          data_end;
		int          n;
		bit          dv;
		logic [15:0] dl16;
		status_t     st;
		res_t        r;
		idx      = int'(pkt_idx);
		data_end = 16 + user_len;
		dv       = (idx >= 16) && !len_ovf && (idx < data_end);

		if (idx < 16 || dv) begin
			crc_run = crc_ccitt_step(crc_run, b);
		end

		// Capture header words, then the trailing CRC
		if (idx == 0) begin
			pid_w[15:8] = b;
		end else if (idx == 1) begin
			pid_w[7:0] = b;
		end else if (idx == 2) begin
			seq_w[15:8] = b;
		end else if (idx == 3) begin
			seq_w[7:0] = b;
		end else if (idx == 4) begin
			len_w[15:8] = b;
		end else if (idx == 5) begin
			len_w[7:0] = b;
			dl16 = len_w - 16'd11;
			if (dl16 > MAX_DATA) begin
				len_ovf  = 1'b1;
				user_len = 0;
			end else begin
				user_len = int'(dl16);
			end
		end else if (idx < 14) begin
			sec_w[63 - 8 * (idx - 6) -: 8] = b;
		end else if (idx == 14) begin
			ack_w[15:8] = b;
		end else if (idx == 15) begin
			ack_w[7:0] = b;
		end else if (!len_ovf) begin
			if (idx == data_end) begin
				rcv_crc[15:8] = b;
			end else if (idx == data_end + 1) begin
				rcv_crc[7:0] = b;
			end
		end

		// Saturate the byte counter
		if (pkt_idx != '1) begin
			pkt_idx = pkt_idx + 1'b1;
		end
		n = int'(pkt_idx);

		r          = '0;
		r.done_res = last;
		r.status   = ST_OK;
		if (last) begin
			if (n < 18) begin
				st = ST_TOO_SHORT;
			end else if (len_ovf) begin
				st = ST_LEN_OVF;
			end else if (n < 18 + user_len) begin
				st = ST_TOO_SHORT;
			end else if (pid_w[15:13] != cfg_ver) begin
				st = ST_BAD_VERSION;
			end else if (pid_w[12] != cfg_typ) begin
				st = ST_BAD_TYPE;
			end else if (crc_run != rcv_crc) begin
				st = ST_BAD_CRC;
			end else begin
				st = ST_OK;
			end
			r.status = st;
			status_tally[int'(st)]++;
		end
		r.data_valid     = dv;
		r.data_byte      = dv ? b : 8'h00;
		r.apid           = pid_w[10:0];
		r.sequence_count = seq_w[13:0];
		r.svc_class      = sec_w[63:56];
		r.svc_subclass   = sec_w[55:48];
		r.origin_id      = sec_w[47:40];
		r.exec_stamp     = sec_w[31:0];
		r.ack_mask       = ack_w;
		r.payload_len    = (n >= 6 && !len_ovf) ? 9'(user_len) : 9'd0;

		if (last) begin
			clear_packet_state();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Compare every accepted result beat with the oldest pending prediction
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no input byte pending");
			end else begin
				want = pending_results.pop_front();
				check_field("done_res", res_ch.done_res, want.done_res);
				check_field("status", res_ch.status, want.status);
				check_field("data_valid", res_ch.data_valid, want.data_valid);
				check_field("data_byte", res_ch.data_byte, want.data_byte);
				check_field("apid", res_ch.apid, want.apid);
				check_field("sequence_count", res_ch.sequence_count, want.sequence_count);
				check_field("svc_class", res_ch.svc_class, want.svc_class);
				check_field("svc_subclass", res_ch.svc_subclass, want.svc_subclass);
				check_field("origin_id", res_ch.origin_id, want.origin_id);
				check_field("exec_stamp", res_ch.exec_stamp, want.exec_stamp);
				check_field("ack_mask", res_ch.ack_mask, want.ack_mask);
				check_field("payload_len", res_ch.payload_len, want.payload_len);
			end
		end
	end

	// Drive result ready: hold off for a counted stretch on request, else random
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] any_byte(input int fill);
		return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
	endfunction

	// Assemble a packet into tx_pkt with a correct trailing CRC; fill < 0 means random
	function automatic void build_packet(input logic [2:0] ver, input logic typ, input int ndata,
		input logic [15:0] len_field, input int fill);
		logic [15:0] crc;
		logic [7:0]  pid_lo;
		pid_lo = any_byte(fill);
		tx_pkt.delete();
		tx_pkt.push_back({ver, typ, pid_lo[3:0]});
		tx_pkt.push_back(any_byte(fill));
		repeat (2) tx_pkt.push_back(any_byte(fill));
		tx_pkt.push_back(len_field[15:8]);
		tx_pkt.push_back(len_field[7:0]);
		repeat (10 + ndata) tx_pkt.push_back(any_byte(fill));
		crc = 16'hFFFF;
		foreach (tx_pkt[k]) begin
			crc = crc_ccitt_step(crc, tx_pkt[k]);
		end
		tx_pkt.push_back(crc[15:8]);
		tx_pkt.push_back(crc[7:0]);
	endfunction

	// Offer one beat, idling at random first; predict it once accepted
	task automatic send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.rx_byte <= b;
		byte_ch.is_last <= last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		pending_results.push_back(parse_byte(b, last));
		beats_sent++;
	endtask

	// Send the first keep bytes of tx_pkt plus extra random bytes, marking the final one
	task automatic send_packet(input int keep, input int extra);
		int total;
		total = keep + extra;
		for (int k = 0; k < total; k++) begin
			send_beat((k < keep) ? tx_pkt[k] : any_byte(-1), k == total - 1);
		end
		packets_sent++;
	endtask

	// Drop valid and wait until every predicted beat has come back
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back, then release the channel
	task automatic set_config(input logic [2:0] ver, input logic typ);
		for (int k = 0; k < 2; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= (k == 0) ? CFG_VERSION : CFG_TYPE;
			cfg_ch.data  <= (k == 0) ? {5'd0, ver} : {7'd0, typ};
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			if (k == 0) begin
				cfg_ver = ver;
			end else begin
				cfg_typ = typ;
			end
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Well-formed packets with no and one data byte
	task automatic test_good_packets();
		set_config(3'd0, 1'b1);
		build_packet(3'd0, 1'b1, 0, 16'd11, -1);
		send_packet(tx_pkt.size(), 0);
		build_packet(3'd0, 1'b1, 1, 16'd12, -1);
		send_packet(tx_pkt.size(), 0);
	endtask

	// At least one packet per error status, plus trailing bytes after the CRC
	task automatic test_status_codes();
		build_packet(3'd3, 1'b1, 0, 16'd11, -1);
		send_packet(tx_pkt.size(), 0);
		build_packet(3'd0, 1'b0, 0, 16'd11, -1);
		send_packet(tx_pkt.size(), 0);
		build_packet(3'd0, 1'b1, 2, 16'd13, -1);
		tx_pkt[tx_pkt.size() - 1] ^= 8'h01;
		send_packet(tx_pkt.size(), 0);
		// too short: inside the header, a lone byte, and inside the data
		build_packet(3'd0, 1'b1, 0, 16'd11, -1);
		send_packet(10, 0);
		send_packet(1, 0);
		build_packet(3'd0, 1'b1, 6, 16'd17, -1);
		send_packet(20, 0);
		// length overflow: just above the limit and wrapped below the bias; an overflowing length cut short reports too short
		build_packet(3'd0, 1'b1, 2, 16'd268, -1);
		send_packet(tx_pkt.size(), 0);
		build_packet(3'd0, 1'b1, 0, 16'd3, -1);
		send_packet(tx_pkt.size(), 0);
		build_packet(3'd0, 1'b1, 0, 16'hFFFF, -1);
		send_packet(12, 0);
		// trailing bytes are ignored
		build_packet(3'd0, 1'b1, 2, 16'd13, -1);
		send_packet(tx_pkt.size(), 3);
	endtask

	// All-ones header with the largest data length, then an all-zero packet
	task automatic test_field_extremes();
		settle();
		set_config(3'd7, 1'b1);
		build_packet(3'd7, 1'b1, MAX_DATA, 16'(MAX_DATA + 11), 8'hFF);
		send_packet(tx_pkt.size(), 0);
		settle();
		set_config(3'd0, 1'b0);
		build_packet(3'd0, 1'b0, 0, 16'd11, 8'h00);
		send_packet(tx_pkt.size(), 0);
	endtask

	// Mostly well-formed packets with random content; the rest broken or noise
	task automatic random_packet();
		int          kind;
		int          ndata;
		int          keep;
		int          extra;
		logic [2:0]  ver;
		logic        typ;
		logic [15:0] len_field;
		kind      = $urandom_range(99);
		ver       = cfg_ver;
		typ       = cfg_typ;
		ndata     = ($urandom_range(11) == 0) ? $urandom_range(MAX_DATA) : $urandom_range(24);
		len_field = 16'(ndata + 11);
		extra     = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
		if (kind >= 55 && kind < 63) begin
			ver = cfg_ver ^ 3'($urandom_range(1, 7));
		end else if (kind >= 63 && kind < 69) begin
			typ = ~cfg_typ;
		end else if (kind >= 87 && kind < 93) begin
			len_field = $urandom_range(1) ? 16'($urandom_range(268, 65535))
				: 16'($urandom_range(10));
		end
		build_packet(ver, typ, ndata, len_field, -1);
		keep = tx_pkt.size();
		if (kind >= 69 && kind < 77) begin
			tx_pkt[keep - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
		end else if (kind >= 77 && kind < 87) begin
			keep  = $urandom_range(1, keep - 1);
			extra = 0;
		end else if (kind >= 93) begin
			tx_pkt.delete();
			repeat ($urandom_range(1, 40)) tx_pkt.push_back(any_byte(-1));
			keep  = tx_pkt.size();
			extra = 0;
		end
		send_packet(keep, extra);
	endtask

	// Three phases: receiver-heavy idling, sender-heavy idling, none
	task automatic test_random_traffic();
		int goal;
		for (int p = 0; p < 3; p++) begin
			settle();
			if (p == 0) begin
				set_config(3'd0, 1'b1);
				tx_idle_pct = 34;
				rx_idle_pct = 58;
			end else if (p == 1) begin
				set_config(3'd7, 1'b0);
				tx_idle_pct = 58;
				rx_idle_pct = 34;
			end else begin
				set_config(3'($urandom_range(7)), 1'($urandom_range(1)));
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			goal = beats_sent + RANDOM_BEATS / 3;
			while (beats_sent < goal) random_packet();
		end
	endtask

	// Hold result ready low for a long stretch while bytes keep coming
	task automatic test_output_stall();
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_left  = STALL_CYCLES;
		repeat (3) begin
			build_packet(cfg_ver, cfg_typ, 40, 16'd51, -1);
			send_packet(tx_pkt.size(), 0);
		end
	endtask

	// Good packet followed by a long run of trailing bytes past the CRC
	task automatic test_long_stream();
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		build_packet(cfg_ver, cfg_typ, 4, 16'd15, -1);
		send_packet(tx_pkt.size(), LONG_TAIL);
	endtask

	initial begin
		arst_n          = 1'b0;
		byte_ch.valid   = 1'b0;
		byte_ch.rx_byte = '0;
		byte_ch.is_last = 1'b0;
		res_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		foreach (status_tally[k]) status_tally[k] = 0;
		clear_packet_state();
		cfg_ver = 3'd0;
		cfg_typ = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 58;
		test_good_packets();
		test_status_codes();
		test_field_extremes();
		test_random_traffic();
		test_output_stall();
		test_long_stream();
		settle();

		$display("Covered %0d packets in %0d bytes over %0d register settings,",
			packets_sent, beats_sent, settings_used);
		$display("  a %0d-cycle output stall and a trailing run; ok %0d short %0d ovf %0d",
			STALL_CYCLES, status_tally[0], status_tally[1], status_tally[2]);
		$display("  ver %0d type %0d crc %0d",
			status_tally[3], status_tally[4], status_tally[5]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
